// ----- sv/brf_pkg.sv -----
// Shared types and status codes for the circular byte FIFO core.
// Depends on nothing; imported by byte_ring_fifo_burst_core.
package brf_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  length;
        logic [63:0] write_data;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_data;
        logic [3:0]  read_count;
        logic [7:0]  pending_count;
        logic [7:0]  free_count;
        logic [1:0]  sticky_error;
        logic        has_data;
    } t_out;

endpackage

// ----- sv/byte_ring_fifo_burst_core.sv -----
// A command accepted in idle runs through the burst states S_RUN and S_DONE before its result is strobed.
// No new command is taken while busy; the single byte-wide store port moves one byte per cycle
// during a burst, and busy drops in the cycle the result is strobed.
// Reset (synchronous, active low) clears both pointers, the fill count and the sticky error.
// The byte store itself is not cleared; only bytes written earlier are ever read back.
// The receiver cannot stall: each result strobe is high for exactly one cycle.
module byte_ring_fifo_burst_core
    import brf_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    // Pointer and count width. The count never exceeds DEPTH-1, so it fits in AW bits.
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Common width for comparing counts against the 4-bit length field.
    localparam int CW  = (AW > 4) ? AW : 4;
    // Width for saturating counts to the 8-bit result fields.
    localparam int SW  = (AW > 8) ? AW : 8;
    // Burst shift register width and step counter width.
    localparam int BW  = MAX_BURST * 8;
    localparam int STW = $clog2(MAX_BURST + 1);

    localparam logic [AW-1:0]  LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [3:0]     BURST_LEN = 4'(MAX_BURST);
    localparam logic [STW-1:0] LAST_STEP = STW'(MAX_BURST);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // Control state.
    t_state        r_state;
    logic [STW-1:0] r_step;
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW-1:0] r_count;
    logic [1:0]    r_err;
    logic          r_rd_vld;

    // Per-command payload held while the burst runs.
    logic          r_cmd;
    logic [3:0]    r_nbytes;
    logic [1:0]    r_status;
    logic [BW-1:0] r_wdata;
    logic [BW-1:0] r_rdata;
    logic [7:0]    r_mem_q;

    // The byte store: one write and one registered read per cycle.
    logic [7:0]    r_mem [DEPTH];

    // Decode of the incoming command, used only when it is accepted.
    logic [3:0]    len_sat;
    logic [AW-1:0] free_now;
    logic          wr_fits;
    logic [3:0]    rd_take;
    logic [1:0]    n_status;
    logic [3:0]    n_nbytes;
    logic [AW-1:0] n_count;
    logic          accept;

    // Step-level control inside a burst.
    logic          move_byte;
    logic [7:0]    shift_in;

    // Result formatting.
    logic [SW-1:0] pend_w;
    logic [SW-1:0] free_w;
    logic [AW-1:0] free_after;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    assign len_sat  = (i_item.length > BURST_LEN) ? BURST_LEN : i_item.length;
    assign free_now = LAST_PTR - r_count;
    assign wr_fits  = !(CW'(free_now) < CW'(len_sat));
    assign rd_take  = (CW'(len_sat) < CW'(r_count)) ? len_sat : 4'(r_count);

    // A rejected write or an empty read moves nothing and leaves the count alone.
    always_comb begin
        n_status = ST_OK;
        n_nbytes = 4'd0;
        n_count  = r_count;
        unique case (i_item.cmd)
            CMD_WRITE: begin
                if (wr_fits) begin
                    n_nbytes = len_sat;
                    n_count  = r_count + AW'(len_sat);
                end else begin
                    n_status = ST_FULL;
                end
            end
            CMD_READ: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_nbytes = rd_take;
                    n_count  = r_count - AW'(rd_take);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Steps 0 .. MAX_BURST-1 each move at most one byte through the store port.
    // The read port is registered and answers in the next cycle, so the read shift register takes its
    // input on steps 1 .. MAX_BURST; zero bytes fill the lanes past the count.
    assign move_byte = (r_step != LAST_STEP) && (4'(r_step) < r_nbytes);
    assign shift_in  = r_rd_vld ? r_mem_q : 8'h00;

    // Main sequencer: state, pointers, count, sticky error and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_count  <= '0;
            r_err    <= ST_OK;
            r_rd_vld <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_rd_vld <= 1'b0;
                    if (accept) begin
                        r_state  <= S_RUN;
                        r_step   <= '0;
                        r_count  <= n_count;
                        if (n_status != ST_OK) begin
                            r_err <= n_status;
                        end
                    end
                end
                S_RUN: begin
                    r_rd_vld <= move_byte && (r_cmd == CMD_READ);
                    if (move_byte && (r_cmd == CMD_WRITE)) begin
                        r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
                    end
                    if (move_byte && (r_cmd == CMD_READ)) begin
                        r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
                    end
                    if (r_step == LAST_STEP) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DONE: begin
                    r_state  <= S_IDLE;
                    o_strobe <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: command decode, write bytes out, read bytes in.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_item.cmd;
            r_nbytes <= n_nbytes;
            r_status <= n_status;
            r_wdata  <= i_item.write_data[BW-1:0];
            r_rdata  <= '0;
        end else if (r_state == S_RUN) begin
            r_wdata <= r_wdata >> 8;
            if (r_step != '0) begin
                r_rdata <= (r_rdata >> 8) | (BW'(shift_in) << (BW - 8));
            end
        end
    end

    // Byte store port.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_RUN) && move_byte && (r_cmd == CMD_WRITE)) begin
            r_mem[r_wptr] <= r_wdata[7:0];
        end
        r_mem_q <= r_mem[r_rptr];
    end

    // Counts saturate at 255 for stores deeper than 256 bytes.
    assign free_after = LAST_PTR - r_count;
    assign pend_w     = SW'(r_count);
    assign free_w     = SW'(free_after);

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            o_result.status        <= r_status;
            o_result.read_data     <= 64'(r_rdata);
            o_result.read_count    <= (r_cmd == CMD_READ) ? r_nbytes : 4'd0;
            o_result.pending_count <= (pend_w > SW'(255)) ? 8'hFF : pend_w[7:0];
            o_result.free_count    <= (free_w > SW'(255)) ? 8'hFF : free_w[7:0];
            o_result.sticky_error  <= r_err;
            o_result.has_data      <= (r_count != '0);
        end
    end

    // A result strobe only ever follows the final formatting cycle.
    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DONE))
        else $error("result strobe without a completed burst");

    // An accepted command keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("command accepted but block not busy");

    // A rejected write or an empty read reports no bytes read.
    a_error_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_OK)) |-> (o_result.read_count == 4'd0))
        else $error("error result carries read bytes");

    // The data flag agrees with the pending count.
    a_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.has_data == (o_result.pending_count != 8'd0)))
        else $error("has_data disagrees with pending count");

    // An error result leaves the sticky record equal to that error.
    a_sticky_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_OK)) |-> (o_result.sticky_error == o_result.status))
        else $error("sticky error not updated by failing command");

endmodule
